>>> rtl/cvsg_pkg.sv
// ----------------------------------------------------------------------------
// cvsg_pkg: shared types and constants of the composite video sample generator
// Timing landmarks of the line and frame, item and result records, and the
// constants of the fixed-point color conversion lanes.
// ----------------------------------------------------------------------------
package cvsg_pkg;

	// Frame geometry
	localparam logic [9:0] SAMPLES_PER_LINE = 10'd635;
	localparam logic [8:0] FRAME_LINES      = 9'd262;
	localparam logic [8:0] ACTIVE_LINES     = 9'd242;
	localparam logic [9:0] ACTIVE_WIDTH     = 10'd526;

	// Line landmarks
	localparam logic [8:0] PIC_LINES = 9'd242;
	localparam logic [8:0] EQ_A_END  = 9'd245;
	localparam logic [8:0] VS_END    = 9'd248;
	localparam logic [8:0] EQ_B_END  = 9'd251;

	// Sample landmarks
	localparam logic [9:0] HSYNC_END     = 10'd47;
	localparam logic [9:0] BLANK_END     = 10'd94;
	localparam logic [9:0] BURST_START   = 10'd53;
	localparam logic [9:0] BURST_END     = 10'd78;
	localparam logic [9:0] TAIL_START    = 10'd620;
	localparam logic [9:0] EQ_PULSE      = 10'd25;
	localparam logic [9:0] EQ_SECOND     = 10'd317;
	localparam logic [9:0] EQ_SECOND_END = 10'd342;
	localparam logic [9:0] VS_FIRST_END  = 10'd272;
	localparam logic [9:0] VS_SECOND_END = 10'd590;

	// Levels
	localparam logic [14:0] PEDESTAL    = 15'd9830;
	localparam logic [14:0] BLANK_RESET = 15'd9830;
	localparam logic [15:0] BURST_RESET = 16'hD99A;

	// Register map (index = paddr[2])
	localparam logic REG_BLANK = 1'b0;
	localparam logic REG_BURST = 1'b1;

	// Queue sizes
	localparam int MID_DEPTH = 2;
	localparam int MID_PTR_W = 1;
	localparam int MID_CNT_W = 2;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = 3;
	localparam int OUT_CNT_W = 4;

	// Conversion lanes: q = floor((a * MUL + HALF) / DEN), a is a magnitude
	localparam int LANES       = 3;
	localparam int LANE_Y      = 0;
	localparam int LANE_U      = 1;
	localparam int LANE_V      = 2;
	localparam int A_W         = 18;
	localparam int NUM_W       = 37;
	localparam int Q_W         = 15;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 21;
	localparam int PROD_W      = A_W + RECIP_W;

	localparam logic [NUM_W-1:0] LANE_MUL [LANES] = '{
		37'd28672, 37'd83968, 37'd449024
	};
	localparam logic [NUM_W-1:0] LANE_DEN [LANES] = '{
		37'd318750, 37'd1328125, 37'd3984375
	};
	localparam logic [NUM_W-1:0] LANE_HALF [LANES] = '{
		37'd159375, 37'd664062, 37'd1992187
	};
	// Reciprocal estimates, low by at most two before the final compare
	localparam logic [RECIP_W-1:0] LANE_RECIP [LANES] = '{
		RECIP_W'((64'd28672 << RECIP_SHIFT) / 64'd318750),
		RECIP_W'((64'd83968 << RECIP_SHIFT) / 64'd1328125),
		RECIP_W'((64'd449024 << RECIP_SHIFT) / 64'd3984375)
	};

	typedef enum logic [1:0] {
		KIND_SYNC,
		KIND_BLANK,
		KIND_BURST,
		KIND_PICTURE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [8:0]  line;
		logic [9:0]  sample;
	} item_t;

	typedef struct packed {
		logic [14:0] luma;
		logic [15:0] u;
		logic [15:0] v;
		logic        taken;
		logic [8:0]  line;
		logic [9:0]  sample;
	} result_t;

endpackage

>>> rtl/composite_video_sample_gen.sv
// ----------------------------------------------------------------------------
// composite_video_sample_gen: baseband composite video sample generator
// Steps through a 262-line frame of 635 samples and emits luma, U and V
// levels with sync, blanking, color burst and converted picture pixels.
// ----------------------------------------------------------------------------
// Each pushed transaction is one sample slot: the block sustains one sample
// per clock while full is low. Pixels are consumed only in active picture
// (pixel_taken high); in every other slot the offered pixel is ignored. A
// result passes a queue, the five-stage conversion pipeline and the result
// queue; the input stalls only when the eight-entry result queue, counting
// the samples still in the pipeline, has no room left. The blanking and burst
// levels are written over the APB port at byte addresses 0 and 4, by the user
// only while no sample is in flight; the block itself does not enforce this.
module composite_video_sample_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               empty,
	input  logic               pop,
	output logic [14:0]        luma_out,
	output logic signed [15:0] chroma_u_out,
	output logic signed [15:0] chroma_v_out,
	output logic               pixel_taken,
	output logic [8:0]         line_index,
	output logic [9:0]         sample_index,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [14:0]        blank_q;
	logic [15:0]        burst_q;
	logic               enq;
	cvsg_pkg::item_t    enq_item;
	logic               mid_valid;
	logic               mid_take;
	cvsg_pkg::item_t    mid_head;
	cvsg_pkg::result_t  result;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= cvsg_pkg::BLANK_RESET;
			burst_q <= cvsg_pkg::BURST_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				cvsg_pkg::REG_BLANK: blank_q <= pwdata[14:0];
				cvsg_pkg::REG_BURST: burst_q <= pwdata[15:0];
				default:             blank_q <= blank_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cvsg_pkg::REG_BLANK: prdata = {17'd0, blank_q};
			cvsg_pkg::REG_BURST: prdata = {16'd0, burst_q};
			default:             prdata = '0;
		endcase
	end

	cvsg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.q_full (full),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.enq    (enq),
		.item   (enq_item)
	);

	cvsg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_item (enq_item),
		.full     (full),
		.deq      (mid_take),
		.valid    (mid_valid),
		.head     (mid_head)
	);

	cvsg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (mid_valid),
		.in_item     (mid_head),
		.in_take     (mid_take),
		.blank_level (blank_q),
		.burst_level (burst_q),
		.pop         (pop),
		.empty       (empty),
		.result      (result)
	);

	// Drive result ports from the queue head
	assign luma_out     = result.luma;
	assign chroma_u_out = result.u;
	assign chroma_v_out = result.v;
	assign pixel_taken  = result.taken;
	assign line_index   = result.line;
	assign sample_index = result.sample;

	// A consumed pixel lies inside the picture area
	a_taken_in_picture: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pixel_taken) |->
			(line_index < cvsg_pkg::ACTIVE_LINES && sample_index >= cvsg_pkg::BLANK_END &&
			 sample_index < cvsg_pkg::TAIL_START))
		else $error("pixel taken outside active picture");

	// V chroma is only ever produced from a picture pixel
	a_v_only_picture: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && chroma_v_out != 16'sd0) |-> pixel_taken)
		else $error("V chroma outside active picture");

	// Positions stay within the frame
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (line_index < cvsg_pkg::FRAME_LINES &&
		            sample_index < cvsg_pkg::SAMPLES_PER_LINE))
		else $error("sample position outside frame");

	// An empty result queue with nothing leaving the pipeline stays empty
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !u_back.v_s5) |=> empty)
		else $error("result appeared without a transaction");

endmodule

>>> rtl/cvsg_front.sv
// ----------------------------------------------------------------------------
// cvsg_front: sample position counters and region classifier
// Accepts one pixel transaction per sample, tags it with its line, sample and
// region kind, and advances the position.
// ----------------------------------------------------------------------------
module cvsg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               q_full,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               enq,
	output cvsg_pkg::item_t    item
);

	logic [9:0]      sample_q;
	logic [8:0]      line_q;
	cvsg_pkg::kind_t kind;

	assign enq = push && !q_full;

	// Classify the current position
	always_comb begin
		kind = cvsg_pkg::KIND_BLANK;
		if (line_q < cvsg_pkg::PIC_LINES) begin
			if (sample_q < cvsg_pkg::HSYNC_END) begin
				kind = cvsg_pkg::KIND_SYNC;
			end else if (sample_q < cvsg_pkg::BLANK_END || sample_q >= cvsg_pkg::TAIL_START) begin
				if (sample_q >= cvsg_pkg::BURST_START && sample_q < cvsg_pkg::BURST_END) begin
					kind = cvsg_pkg::KIND_BURST;
				end
			end else if (line_q < cvsg_pkg::ACTIVE_LINES &&
					sample_q < cvsg_pkg::BLANK_END + cvsg_pkg::ACTIVE_WIDTH) begin
				kind = cvsg_pkg::KIND_PICTURE;
			end
		end else if (line_q < cvsg_pkg::EQ_A_END ||
				(line_q >= cvsg_pkg::VS_END && line_q < cvsg_pkg::EQ_B_END)) begin
			if (sample_q < cvsg_pkg::EQ_PULSE ||
					(sample_q >= cvsg_pkg::EQ_SECOND && sample_q < cvsg_pkg::EQ_SECOND_END)) begin
				kind = cvsg_pkg::KIND_SYNC;
			end
		end else if (line_q < cvsg_pkg::VS_END) begin
			if (sample_q < cvsg_pkg::VS_FIRST_END ||
					(sample_q >= cvsg_pkg::EQ_SECOND && sample_q < cvsg_pkg::VS_SECOND_END)) begin
				kind = cvsg_pkg::KIND_SYNC;
			end
		end else begin
			if (sample_q < cvsg_pkg::HSYNC_END) begin
				kind = cvsg_pkg::KIND_SYNC;
			end
		end
	end

	// Build the tagged item
	always_comb begin
		item.kind   = kind;
		item.red    = red;
		item.green  = green;
		item.blue   = blue;
		item.line   = line_q;
		item.sample = sample_q;
	end

	// Advance the position on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			line_q   <= '0;
		end else if (enq) begin
			if (sample_q >= cvsg_pkg::SAMPLES_PER_LINE - 10'd1) begin
				sample_q <= '0;
				if (line_q >= cvsg_pkg::FRAME_LINES - 9'd1) begin
					line_q <= '0;
				end else begin
					line_q <= line_q + 9'd1;
				end
			end else begin
				sample_q <= sample_q + 10'd1;
			end
		end
	end

endmodule

>>> rtl/cvsg_queue.sv
// ----------------------------------------------------------------------------
// cvsg_queue: short queue between classifier and arithmetic
// Holds tagged items so that the front and the back stall independently.
// ----------------------------------------------------------------------------
module cvsg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enq,
	input  cvsg_pkg::item_t    enq_item,
	output logic               full,
	input  logic               deq,
	output logic               valid,
	output cvsg_pkg::item_t    head
);

	cvsg_pkg::item_t                 mem_q [cvsg_pkg::MID_DEPTH];
	logic [cvsg_pkg::MID_PTR_W-1:0]  wr_ptr_q;
	logic [cvsg_pkg::MID_PTR_W-1:0]  rd_ptr_q;
	logic [cvsg_pkg::MID_CNT_W-1:0]  count_q;

	assign full  = (count_q == cvsg_pkg::MID_CNT_W'(cvsg_pkg::MID_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Store incoming items
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= enq_item;
		end
	end

	// Track pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/cvsg_back.sv
// ----------------------------------------------------------------------------
// cvsg_back: level generation and color conversion
// Five-stage pipeline that turns tagged items into luma and chroma levels,
// with an eight-entry result queue; items enter only when the queue has room
// for everything in flight.
// ----------------------------------------------------------------------------
module cvsg_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  cvsg_pkg::item_t        in_item,
	output logic                   in_take,
	input  logic [14:0]            blank_level,
	input  logic [15:0]            burst_level,
	input  logic                   pop,
	output logic                   empty,
	output cvsg_pkg::result_t      result
);

	typedef struct packed {
		cvsg_pkg::kind_t kind;
		logic [8:0]      line;
		logic [9:0]      sample;
	} meta_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;

	logic [cvsg_pkg::A_W-1:0] ys_s1;
	logic [cvsg_pkg::A_W-1:0] rk_s1;
	logic [cvsg_pkg::A_W-1:0] bk_s1;

	logic [cvsg_pkg::A_W-1:0]   a_s2   [cvsg_pkg::LANES];
	logic [cvsg_pkg::LANES-1:0] neg_s2, neg_s3, neg_s4, neg_s5;
	logic [cvsg_pkg::NUM_W-1:0] num_s3 [cvsg_pkg::LANES];
	logic [cvsg_pkg::Q_W-1:0]   q0_s3  [cvsg_pkg::LANES];
	logic [cvsg_pkg::NUM_W-1:0] num_s4 [cvsg_pkg::LANES];
	logic [cvsg_pkg::NUM_W-1:0] qd_s4  [cvsg_pkg::LANES];
	logic [cvsg_pkg::Q_W-1:0]   q0_s4  [cvsg_pkg::LANES];
	logic [cvsg_pkg::Q_W-1:0]   q_s5   [cvsg_pkg::LANES];

	logic [cvsg_pkg::A_W-1:0] ys;
	logic [cvsg_pkg::A_W:0]   diff_u;
	logic [cvsg_pkg::A_W:0]   diff_v;
	logic [cvsg_pkg::A_W-1:0] a_next   [cvsg_pkg::LANES];
	logic [cvsg_pkg::LANES-1:0] neg_next;
	logic [cvsg_pkg::Q_W:0]   luma_sum;

	cvsg_pkg::result_t                res_s5;
	cvsg_pkg::result_t                mem_q [cvsg_pkg::OUT_DEPTH];
	logic [cvsg_pkg::OUT_PTR_W-1:0]   wr_ptr_q;
	logic [cvsg_pkg::OUT_PTR_W-1:0]   rd_ptr_q;
	logic [cvsg_pkg::OUT_CNT_W-1:0]   count_q;
	logic [2:0]                       inflight;
	logic                             do_pop;

	// Admit an item only when the result queue can absorb all in flight
	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);
	assign in_take  = in_valid &&
		((count_q + cvsg_pkg::OUT_CNT_W'(inflight)) < cvsg_pkg::OUT_CNT_W'(cvsg_pkg::OUT_DEPTH));

	// Stage 1: weighted luma sum and scaled color components
	assign ys = cvsg_pkg::A_W'(in_item.red)   * 18'd299 +
	            cvsg_pkg::A_W'(in_item.green) * 18'd587 +
	            cvsg_pkg::A_W'(in_item.blue)  * 18'd114;

	always_ff @(posedge clk) begin
		meta_s1 <= '{kind: in_item.kind, line: in_item.line, sample: in_item.sample};
		ys_s1   <= ys;
		rk_s1   <= cvsg_pkg::A_W'(in_item.red)  * 18'd1000;
		bk_s1   <= cvsg_pkg::A_W'(in_item.blue) * 18'd1000;
	end

	// Stage 2: color differences as sign and magnitude
	assign diff_u = {1'b0, bk_s1} - {1'b0, ys_s1};
	assign diff_v = {1'b0, rk_s1} - {1'b0, ys_s1};

	always_comb begin
		a_next[cvsg_pkg::LANE_Y]   = ys_s1;
		neg_next[cvsg_pkg::LANE_Y] = 1'b0;
		neg_next[cvsg_pkg::LANE_U] = diff_u[cvsg_pkg::A_W];
		neg_next[cvsg_pkg::LANE_V] = diff_v[cvsg_pkg::A_W];
		a_next[cvsg_pkg::LANE_U]   = diff_u[cvsg_pkg::A_W] ?
			cvsg_pkg::A_W'(-diff_u) : diff_u[cvsg_pkg::A_W-1:0];
		a_next[cvsg_pkg::LANE_V]   = diff_v[cvsg_pkg::A_W] ?
			cvsg_pkg::A_W'(-diff_v) : diff_v[cvsg_pkg::A_W-1:0];
	end

	always_ff @(posedge clk) begin
		meta_s2 <= meta_s1;
		neg_s2  <= neg_next;
		a_s2    <= a_next;
		meta_s3 <= meta_s2;
		neg_s3  <= neg_s2;
		meta_s4 <= meta_s3;
		neg_s4  <= neg_s3;
		meta_s5 <= meta_s4;
		neg_s5  <= neg_s4;
	end

	// Stages 3 to 5: rounded scaling per lane by reciprocal and correction
	for (genvar i = 0; i < cvsg_pkg::LANES; i++) begin : g_lane
		logic [cvsg_pkg::PROD_W-1:0] est;
		logic [cvsg_pkg::NUM_W-1:0]  rem;

		assign est = cvsg_pkg::PROD_W'(a_s2[i]) * cvsg_pkg::PROD_W'(cvsg_pkg::LANE_RECIP[i]);
		assign rem = num_s4[i] - qd_s4[i];

		always_ff @(posedge clk) begin
			num_s3[i] <= cvsg_pkg::NUM_W'(a_s2[i]) * cvsg_pkg::LANE_MUL[i] +
			             cvsg_pkg::LANE_HALF[i];
			q0_s3[i]  <= est[cvsg_pkg::RECIP_SHIFT +: cvsg_pkg::Q_W];
			num_s4[i] <= num_s3[i];
			q0_s4[i]  <= q0_s3[i];
			qd_s4[i]  <= cvsg_pkg::NUM_W'(q0_s3[i]) * cvsg_pkg::LANE_DEN[i];
			q_s5[i]   <= q0_s4[i] +
			             cvsg_pkg::Q_W'(rem >= cvsg_pkg::LANE_DEN[i]) +
			             cvsg_pkg::Q_W'(rem >= (cvsg_pkg::LANE_DEN[i] << 1));
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Add the pedestal to the picture luma, clip at full scale
	assign luma_sum = {1'b0, q_s5[cvsg_pkg::LANE_Y]} + {1'b0, cvsg_pkg::PEDESTAL};

	// Select the levels for the region
	always_comb begin
		res_s5.line   = meta_s5.line;
		res_s5.sample = meta_s5.sample;
		res_s5.taken  = (meta_s5.kind == cvsg_pkg::KIND_PICTURE);
		res_s5.u      = '0;
		res_s5.v      = '0;
		unique case (meta_s5.kind)
			cvsg_pkg::KIND_SYNC: begin
				res_s5.luma = '0;
			end
			cvsg_pkg::KIND_BLANK: begin
				res_s5.luma = blank_level;
			end
			cvsg_pkg::KIND_BURST: begin
				res_s5.luma = blank_level;
				res_s5.u    = burst_level;
			end
			cvsg_pkg::KIND_PICTURE: begin
				res_s5.luma = luma_sum[cvsg_pkg::Q_W] ? '1 : luma_sum[cvsg_pkg::Q_W-1:0];
				res_s5.u    = neg_s5[cvsg_pkg::LANE_U] ?
					-{1'b0, q_s5[cvsg_pkg::LANE_U]} : {1'b0, q_s5[cvsg_pkg::LANE_U]};
				res_s5.v    = neg_s5[cvsg_pkg::LANE_V] ?
					-{1'b0, q_s5[cvsg_pkg::LANE_V]} : {1'b0, q_s5[cvsg_pkg::LANE_V]};
			end
			default: begin
				res_s5.luma = '0;
			end
		endcase
	end

	// Result queue
	assign empty  = (count_q == '0);
	assign result = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (v_s5) begin
			mem_q[wr_ptr_q] <= res_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (v_s5) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({v_s5, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for the composite video sample generator
// Streams RGB pixels through the first full line and into the next one:
// sync, blanking, color burst, picture with corner colors, the tail blank and
// the line wrap. A local timing and color-conversion predictor checks every
// output sample. Both handshakes idle in random bursts. The blanking and
// burst levels are reprogrammed between traffic phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DRAIN_CYCLES = 24;
	localparam int NUM_PHASES   = 5;
	localparam int N_CORNERS    = 16;
	localparam int CORNER_START = 94;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Transactions per phase; together they cover one line plus a few samples
	localparam int PHASE_LEN [NUM_PHASES] = '{130, 130, 130, 130, 130};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [14:0] luma_out;
	logic signed [15:0] chroma_u_out;
	logic signed [15:0] chroma_v_out;
	logic        pixel_taken;
	logic [8:0]  line_index;
	logic [9:0]  sample_index;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	composite_video_sample_gen dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.empty        (empty),
		.pop          (pop),
		.luma_out     (luma_out),
		.chroma_u_out (chroma_u_out),
		.chroma_v_out (chroma_v_out),
		.pixel_taken  (pixel_taken),
		.line_index   (line_index),
		.sample_index (sample_index),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Corner colors placed at the start of the first picture line
	logic [23:0] corner_rgb [N_CORNERS] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
		24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
		24'h808080, 24'h7F7F7F, 24'h010101, 24'hFEFEFE,
		24'h800000, 24'h008000, 24'h000080, 24'h55AAFF
	};

	pixel_t            pixel_pending_q [$];
	cvsg_pkg::result_t sample_expect_q [$];

	// Predictor state: raster position and programmed levels
	logic [9:0]  sample_pos;
	logic [8:0]  line_pos;
	logic [14:0] blank_cfg;
	logic [15:0] burst_cfg;

	int error_count      = 0;
	int samples_checked  = 0;
	int pixels_converted = 0;
	int frame_wraps      = 0;
	int reg_writes       = 0;
	logic calm = 1'b0;

	logic       send_idle = 1'b0;
	int         send_gap  = 0;
	int         send_mode_left = 0;
	logic       recv_idle = 1'b0;
	int         recv_gap  = 0;
	int         recv_mode_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Round to nearest, ties away from zero
	function automatic longint round_div(input longint num, input longint den);
		if (num < 0)
			return -((-num + den / 2) / den);
		return (num + den / 2) / den;
	endfunction

	function automatic longint clamp_s16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Compute the sample for the current raster slot, then advance the raster
	function automatic cvsg_pkg::result_t video_sample_predict(input pixel_t px);
		cvsg_pkg::result_t r;
		longint  ys, y;
		int      s, l;
		s = int'(sample_pos);
		l = int'(line_pos);
		r.luma  = blank_cfg;
		r.u     = '0;
		r.v     = '0;
		r.taken = 1'b0;
		r.line  = line_pos;
		r.sample = sample_pos;
		if (l < int'(cvsg_pkg::PIC_LINES)) begin
			if (s < int'(cvsg_pkg::HSYNC_END)) begin
				r.luma = '0;
			end else if (s < int'(cvsg_pkg::BLANK_END) || s >= int'(cvsg_pkg::TAIL_START)) begin
				if (s >= int'(cvsg_pkg::BURST_START) && s < int'(cvsg_pkg::BURST_END))
					r.u = burst_cfg;
			end else if (l < int'(cvsg_pkg::ACTIVE_LINES) &&
					s < int'(cvsg_pkg::BLANK_END) + int'(cvsg_pkg::ACTIVE_WIDTH)) begin
				ys = 299 * longint'(px.red) + 587 * longint'(px.green)
					+ 114 * longint'(px.blue);
				y = round_div(ys * 7 * 32768, 2550000) + longint'(cvsg_pkg::PEDESTAL);
				if (y > 32767)
					y = 32767;
				r.luma  = 15'(y);
				r.u     = 16'(clamp_s16(round_div(492 * (1000 * longint'(px.blue) - ys)
					* 32768, 255000000)));
				r.v     = 16'(clamp_s16(round_div(877 * (1000 * longint'(px.red) - ys)
					* 32768, 255000000)));
				r.taken = 1'b1;
			end
		end else if (l < int'(cvsg_pkg::EQ_A_END) ||
				(l >= int'(cvsg_pkg::VS_END) && l < int'(cvsg_pkg::EQ_B_END))) begin
			if (s < int'(cvsg_pkg::EQ_PULSE) ||
					(s >= int'(cvsg_pkg::EQ_SECOND) && s < int'(cvsg_pkg::EQ_SECOND_END)))
				r.luma = '0;
		end else if (l < int'(cvsg_pkg::VS_END)) begin
			if (s < int'(cvsg_pkg::VS_FIRST_END) ||
					(s >= int'(cvsg_pkg::EQ_SECOND) && s < int'(cvsg_pkg::VS_SECOND_END)))
				r.luma = '0;
		end else if (s < int'(cvsg_pkg::HSYNC_END)) begin
			r.luma = '0;
		end
		// Advance the raster, wrapping line and frame
		if (s >= int'(cvsg_pkg::SAMPLES_PER_LINE) - 1) begin
			sample_pos = '0;
			if (l >= int'(cvsg_pkg::FRAME_LINES) - 1) begin
				line_pos = '0;
				frame_wraps++;
			end else begin
				line_pos = line_pos + 9'd1;
			end
		end else begin
			sample_pos = sample_pos + 10'd1;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input cvsg_pkg::result_t want,
			input longint exp_val, input longint act_val);
		if (exp_val !== act_val) begin
			error_count++;
			$display("%0t: %s mismatch at line %0d sample %0d: expected %0d, actual %0d",
				$time, name, want.line, want.sample, exp_val, act_val);
		end
	endtask

	// Drive pixel transactions from the pending queue, idling in bursts
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		logic   accepted;
		pixel_t nxt;
		if (!arst_n) begin
			push     <= 1'b0;
			send_gap <= 0;
		end else begin
			accepted = push && !full;
			if (accepted) begin
				sample_expect_q.push_back(video_sample_predict(pixel_pending_q[0]));
				pixel_pending_q.pop_front();
			end
			if (send_mode_left == 0) begin
				send_idle      <= ($urandom_range(0, 3) != 0);
				send_mode_left <= $urandom_range(100, 1500);
			end else begin
				send_mode_left <= send_mode_left - 1;
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				push     <= 1'b0;
			end else if (pixel_pending_q.size() == 0) begin
				push <= 1'b0;
			end else if (!calm && send_idle && (!push || accepted) &&
					$urandom_range(0, 9) == 0) begin
				// Hold off for a random idle burst
				send_gap <= $urandom_range(0, 8);
				push     <= 1'b0;
			end else begin
				nxt   = pixel_pending_q[0];
				push  <= 1'b1;
				red   <= nxt.red;
				green <= nxt.green;
				blue  <= nxt.blue;
			end
		end
	end

	// Accept output samples and compare against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : sample_monitor
		cvsg_pkg::result_t want;
		if (!arst_n) begin
			pop      <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (pop && !empty) begin
				if (sample_expect_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected sample: expected none, actual line %0d sample %0d",
						$time, line_index, sample_index);
				end else begin
					want = sample_expect_q.pop_front();
					samples_checked++;
					if (want.taken)
						pixels_converted++;
					check_field("luma_out", want, want.luma, luma_out);
					check_field("chroma_u_out", want, $signed(want.u), chroma_u_out);
					check_field("chroma_v_out", want, $signed(want.v), chroma_v_out);
					check_field("pixel_taken", want, want.taken, pixel_taken);
					check_field("line_index", want, want.line, line_index);
					check_field("sample_index", want, want.sample, sample_index);
				end
			end
			if (recv_mode_left == 0) begin
				recv_idle      <= ($urandom_range(0, 3) != 0);
				recv_mode_left <= $urandom_range(100, 1500);
			end else begin
				recv_mode_left <= recv_mode_left - 1;
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				pop      <= 1'b0;
			end else if (!calm && recv_idle && $urandom_range(0, 7) == 0) begin
				// Stall the consumer for a random idle burst
				recv_gap <= $urandom_range(0, 8);
				pop      <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] data, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input logic [2:0] addr, input logic [31:0] want,
			input logic [31:0] mask);
		logic [31:0] rd;
		apb_access(1'b0, addr, '0, rd);
		if ((rd & mask) !== (want & mask)) begin
			error_count++;
			$display("%0t: register read at %0d: expected %0h, actual %0h",
				$time, addr, want & mask, rd & mask);
		end
	endtask

	// Program both levels with junk in the unused upper bits, then read back
	task automatic set_levels(input logic [14:0] blank, input logic [15:0] burst);
		logic [31:0] rd;
		apb_access(1'b1, {cvsg_pkg::REG_BLANK, 2'b00}, {17'($urandom), blank}, rd);
		apb_access(1'b1, {cvsg_pkg::REG_BURST, 2'b00}, {16'($urandom), burst}, rd);
		blank_cfg = blank;
		burst_cfg = burst;
		reg_writes += 2;
		check_reg({cvsg_pkg::REG_BLANK, 2'b00}, 32'(blank), 32'h0000_7FFF);
		check_reg({cvsg_pkg::REG_BURST, 2'b00}, 32'(burst), 32'h0000_FFFF);
	endtask

	initial begin : run_control
		int     serial;
		pixel_t px;
		serial     = 0;
		blank_cfg  = cvsg_pkg::BLANK_RESET;
		burst_cfg  = cvsg_pkg::BURST_RESET;
		sample_pos = '0;
		line_pos   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		check_reg({cvsg_pkg::REG_BLANK, 2'b00}, 32'(cvsg_pkg::BLANK_RESET), 32'h0000_7FFF);
		check_reg({cvsg_pkg::REG_BURST, 2'b00}, 32'(cvsg_pkg::BURST_RESET), 32'h0000_FFFF);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				1: set_levels(15'd0, 16'h7FFF);
				2: set_levels(15'($urandom), 16'($urandom));
				3: set_levels(15'h7FFF, 16'h8000);
				4: set_levels(15'($urandom), 16'($urandom));
				default: ;
			endcase
			if (phase == NUM_PHASES - 1)
				calm = 1'b1;
			@(negedge clk);
			for (int i = 0; i < PHASE_LEN[phase]; i++) begin
				if (serial >= CORNER_START && serial < CORNER_START + N_CORNERS) begin
					{px.red, px.green, px.blue} = corner_rgb[serial - CORNER_START];
				end else if ($urandom_range(0, 15) == 0) begin
					// Pick each component at full scale or zero
					px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end else begin
					px.red   = $urandom_range(0, 255);
					px.green = $urandom_range(0, 255);
					px.blue  = $urandom_range(0, 255);
				end
				pixel_pending_q.push_back(px);
				serial++;
			end
			// Drain all traffic before touching the registers again
			while (pixel_pending_q.size() != 0 || sample_expect_q.size() != 0)
				@(negedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end

		if (sample_expect_q.size() != 0) begin
			error_count++;
			$display("%0t: %0d samples never arrived", $time, sample_expect_q.size());
		end
		$display("Checked %0d samples (%0d converted pixels) across %0d frame wraps,",
			samples_checked, pixels_converted, frame_wraps);
		$display("with %0d level register writes over %0d phases.", reg_writes, NUM_PHASES);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
